// ===== design/rwc_pkg.sv =====
// Shared types, widths and register codes for the ROI weighted centroid block.
// No dependencies; used by every module of the block.
`default_nettype none
package rwc_pkg;

	localparam int COORD_BITS = 12;
	localparam int PIXEL_BITS = 16;
	localparam int FRAC_BITS  = 8;

	localparam int SPAN_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = PIXEL_BITS + COORD_BITS;
	localparam int SUM_BITS   = PIXEL_BITS + 2 * COORD_BITS;
	localparam int WSUM_BITS  = SUM_BITS + COORD_BITS;
	localparam int CENT_BITS  = COORD_BITS + FRAC_BITS;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = SPAN_BITS;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

	localparam logic [COORD_BITS-1:0] RST_ROI_LEFT    = COORD_BITS'(40);
	localparam logic [COORD_BITS-1:0] RST_ROI_TOP     = COORD_BITS'(20);
	localparam logic [SPAN_BITS-1:0]  RST_ROI_WIDTH   = SPAN_BITS'(50);
	localparam logic [SPAN_BITS-1:0]  RST_ROI_HEIGHT  = SPAN_BITS'(50);
	localparam logic [SPAN_BITS-1:0]  RST_FRAME_WIDTH = SPAN_BITS'(656);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ROI_LEFT    = 3'd0,
		REG_ROI_TOP     = 3'd1,
		REG_ROI_WIDTH   = 3'd2,
		REG_ROI_HEIGHT  = 3'd3,
		REG_FRAME_WIDTH = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] roi_left;
		logic [COORD_BITS-1:0] roi_top;
		logic [SPAN_BITS-1:0]  roi_width;
		logic [SPAN_BITS-1:0]  roi_height;
		logic [SPAN_BITS-1:0]  frame_width;
	} cfg_t;

	// one classified pixel handed from front to back
	typedef struct packed {
		logic [PIXEL_BITS-1:0] pixel;
		logic [COORD_BITS-1:0] dc;
		logic [COORD_BITS-1:0] dr;
		logic                  hit;
		logic                  last;
	} entry_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

endpackage
`default_nettype wire

// ===== design/roi_weighted_centroid.sv =====
// Region-of-interest intensity-weighted centroid, top level.
// Depends on rwc_pkg, rwc_front, rwc_fifo and rwc_back.
//
// Pixels stream in one per cycle in row-major order; pixels inside the
// configured rectangle are summed and weighted by their column and row offset.
// The frame_end pixel produces one result: sum, both centroids in 12.8 fixed
// point (rounded toward zero, saturated) and an empty flag when the sum is
// zero. Sustained rate is one pixel per clock, set by the multiply and
// accumulate stage, while no frame end waits for the divider. The restoring
// divider gives one quotient bit per cycle for both axes at frame end; it
// runs beside accumulation of the next frame, and a further frame end waits
// only while the divider or its held result is still occupied. pix_ready
// drops only when the four-entry queue between front and back end fills.
// Configuration writes are always accepted and must happen while idle.
`default_nettype none
module roi_weighted_centroid (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [rwc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [rwc_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  wire logic                              pix_valid,
	output logic                                   pix_ready,
	input  wire logic [rwc_pkg::PIXEL_BITS-1:0]    pixel,
	input  wire logic                              frame_end,
	output logic                                   res_valid,
	input  wire logic                              res_ready,
	output logic [rwc_pkg::SUM_BITS-1:0]           total_intensity,
	output logic [rwc_pkg::CENT_BITS-1:0]          centroid_col,
	output logic [rwc_pkg::CENT_BITS-1:0]          centroid_row,
	output logic                                   empty_region
);

	rwc_pkg::cfg_t   cfg_q;
	rwc_pkg::entry_t wr_entry, head;
	logic fifo_full, head_valid, push, pop;

	assign cfg_ready = 1'b1;
	assign pix_ready = !fifo_full;
	assign push      = pix_valid && pix_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.roi_left    <= rwc_pkg::RST_ROI_LEFT;
			cfg_q.roi_top     <= rwc_pkg::RST_ROI_TOP;
			cfg_q.roi_width   <= rwc_pkg::RST_ROI_WIDTH;
			cfg_q.roi_height  <= rwc_pkg::RST_ROI_HEIGHT;
			cfg_q.frame_width <= rwc_pkg::RST_FRAME_WIDTH;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rwc_pkg::REG_ROI_LEFT:
					cfg_q.roi_left <= cfg_data[rwc_pkg::COORD_BITS-1:0];
				rwc_pkg::REG_ROI_TOP:
					cfg_q.roi_top <= cfg_data[rwc_pkg::COORD_BITS-1:0];
				rwc_pkg::REG_ROI_WIDTH:
					cfg_q.roi_width <= cfg_data[rwc_pkg::SPAN_BITS-1:0];
				rwc_pkg::REG_ROI_HEIGHT:
					cfg_q.roi_height <= cfg_data[rwc_pkg::SPAN_BITS-1:0];
				rwc_pkg::REG_FRAME_WIDTH:
					cfg_q.frame_width <= cfg_data[rwc_pkg::SPAN_BITS-1:0];
				default: ;
			endcase
		end
	end

	rwc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.pixel     (pixel),
		.frame_end (frame_end),
		.entry     (wr_entry)
	);

	rwc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (wr_entry),
		.full      (fifo_full),
		.pop       (pop),
		.not_empty (head_valid),
		.rd_entry  (head)
	);

	rwc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_valid      (head_valid),
		.head            (head),
		.pop             (pop),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.total_intensity (total_intensity),
		.centroid_col    (centroid_col),
		.centroid_row    (centroid_row),
		.empty_region    (empty_region)
	);

	// empty result carries zero sum and zero centroids
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && empty_region |->
			total_intensity == '0 && centroid_col == '0 && centroid_row == '0)
		else $error("empty result with non-zero fields");

	// a non-empty result always has a non-zero sum
	a_sum_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !empty_region |-> total_intensity != '0)
		else $error("non-empty result with zero sum");

	// the queue is never popped when empty
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

endmodule
`default_nettype wire

// ===== design/rwc_front.sv =====
// Front end: raster position counters and region classification.
// Depends on rwc_pkg.
`default_nettype none
module rwc_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire rwc_pkg::cfg_t                  cfg,
	input  wire logic                           push,
	input  wire logic [rwc_pkg::PIXEL_BITS-1:0] pixel,
	input  wire logic                           frame_end,
	output rwc_pkg::entry_t                     entry
);

	logic [rwc_pkg::COORD_BITS-1:0] col_q, row_q;
	logic [rwc_pkg::COORD_BITS-1:0] col_off, row_off;
	logic in_col, in_row, row_end;

	always_comb begin
		col_off = col_q - cfg.roi_left;
		row_off = row_q - cfg.roi_top;
		in_col  = (col_q >= cfg.roi_left) && ({1'b0, col_off} < cfg.roi_width);
		in_row  = (row_q >= cfg.roi_top) && ({1'b0, row_off} < cfg.roi_height);
		row_end = (({1'b0, col_q} + rwc_pkg::SPAN_BITS'(1)) >= cfg.frame_width)
			|| (col_q == rwc_pkg::COORD_MAX);
		entry.pixel = pixel;
		entry.dc    = col_off;
		entry.dr    = row_off;
		entry.hit   = in_col && in_row;
		entry.last  = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + rwc_pkg::COORD_BITS'(1);
			end else begin
				col_q <= col_q + rwc_pkg::COORD_BITS'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/rwc_fifo.sv =====
// Short queue of classified pixels between front and back.
// Depends on rwc_pkg.
`default_nettype none
module rwc_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire rwc_pkg::entry_t wr_entry,
	output logic                 full,
	input  wire logic            pop,
	output logic                 not_empty,
	output rwc_pkg::entry_t      rd_entry
);

	rwc_pkg::entry_t mem_q [rwc_pkg::FIFO_DEPTH];
	logic [rwc_pkg::FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [rwc_pkg::FIFO_CNT_BITS-1:0] count_q;

	assign full      = (count_q == rwc_pkg::FIFO_CNT_BITS'(rwc_pkg::FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + rwc_pkg::FIFO_PTR_BITS'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + rwc_pkg::FIFO_PTR_BITS'(1);
			if (push && !pop)
				count_q <= count_q + rwc_pkg::FIFO_CNT_BITS'(1);
			else if (pop && !push)
				count_q <= count_q - rwc_pkg::FIFO_CNT_BITS'(1);
		end
	end

endmodule
`default_nettype wire

// ===== design/rwc_div.sv =====
// Frame-end centroid divider: restoring division, one quotient bit per cycle
// for both axes, holding the result until it is taken. Depends on rwc_pkg.
`default_nettype none
module rwc_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [rwc_pkg::SUM_BITS-1:0]  den,
	input  wire logic [rwc_pkg::WSUM_BITS-1:0] num_c,
	input  wire logic [rwc_pkg::WSUM_BITS-1:0] num_r,
	output logic                               busy,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output logic [rwc_pkg::SUM_BITS-1:0]       total_intensity,
	output logic [rwc_pkg::CENT_BITS-1:0]      centroid_col,
	output logic [rwc_pkg::CENT_BITS-1:0]      centroid_row,
	output logic                               empty_region
);

	localparam int STEP_BITS = $clog2(rwc_pkg::CENT_BITS + 1);
	localparam int NUM_EXT_BITS = rwc_pkg::WSUM_BITS + rwc_pkg::FRAC_BITS;

	rwc_pkg::div_state_t state_q, state_d;
	logic [rwc_pkg::SUM_BITS-1:0]  den_q, rem_c_q, rem_r_q;
	logic [rwc_pkg::CENT_BITS-1:0] lo_c_q, lo_r_q;
	logic [STEP_BITS-1:0]          step_q;
	logic ovf_c_q, ovf_r_q, empty_q;

	logic [rwc_pkg::SUM_BITS:0]    trial_c, trial_r;
	logic                          take_c, take_r;
	logic [rwc_pkg::WSUM_BITS-1:0] den_lim;
	logic [NUM_EXT_BITS-1:0]       ext_c, ext_r;
	logic                          last_step;

	always_comb begin
		// numerator is num * 2^FRAC; upper part seeds the remainder
		ext_c   = NUM_EXT_BITS'(num_c) << rwc_pkg::FRAC_BITS;
		ext_r   = NUM_EXT_BITS'(num_r) << rwc_pkg::FRAC_BITS;
		// quotient overflows the centroid width when num >= den * 2^COORD
		den_lim = rwc_pkg::WSUM_BITS'(den) << rwc_pkg::COORD_BITS;
		trial_c = {rem_c_q, lo_c_q[rwc_pkg::CENT_BITS-1]};
		trial_r = {rem_r_q, lo_r_q[rwc_pkg::CENT_BITS-1]};
		take_c  = trial_c >= {1'b0, den_q};
		take_r  = trial_r >= {1'b0, den_q};
		last_step = (step_q == STEP_BITS'(rwc_pkg::CENT_BITS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rwc_pkg::DIV_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		res_valid = 1'b0;
		unique case (state_q)
			rwc_pkg::DIV_IDLE: begin
				busy = 1'b0;
				if (start)
					state_d = (den == '0) ? rwc_pkg::DIV_DONE : rwc_pkg::DIV_RUN;
			end
			rwc_pkg::DIV_RUN: begin
				if (last_step)
					state_d = rwc_pkg::DIV_DONE;
			end
			rwc_pkg::DIV_DONE: begin
				res_valid = 1'b1;
				if (res_ready)
					state_d = rwc_pkg::DIV_IDLE;
			end
			default: state_d = rwc_pkg::DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (state_q == rwc_pkg::DIV_IDLE) begin
			step_q <= '0;
		end else if (state_q == rwc_pkg::DIV_RUN) begin
			step_q <= step_q + STEP_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rwc_pkg::DIV_IDLE && start) begin
			den_q   <= den;
			empty_q <= (den == '0);
			ovf_c_q <= (num_c >= den_lim);
			ovf_r_q <= (num_r >= den_lim);
			rem_c_q <= rwc_pkg::SUM_BITS'(ext_c >> rwc_pkg::CENT_BITS);
			rem_r_q <= rwc_pkg::SUM_BITS'(ext_r >> rwc_pkg::CENT_BITS);
			lo_c_q  <= ext_c[rwc_pkg::CENT_BITS-1:0];
			lo_r_q  <= ext_r[rwc_pkg::CENT_BITS-1:0];
		end else if (state_q == rwc_pkg::DIV_RUN) begin
			rem_c_q <= take_c ? rwc_pkg::SUM_BITS'(trial_c - {1'b0, den_q})
				: rwc_pkg::SUM_BITS'(trial_c);
			rem_r_q <= take_r ? rwc_pkg::SUM_BITS'(trial_r - {1'b0, den_q})
				: rwc_pkg::SUM_BITS'(trial_r);
			lo_c_q  <= {lo_c_q[rwc_pkg::CENT_BITS-2:0], take_c};
			lo_r_q  <= {lo_r_q[rwc_pkg::CENT_BITS-2:0], take_r};
		end
	end

	always_comb begin
		total_intensity = den_q;
		empty_region    = empty_q;
		if (empty_q) begin
			centroid_col = '0;
			centroid_row = '0;
		end else begin
			centroid_col = ovf_c_q ? '1 : lo_c_q;
			centroid_row = ovf_r_q ? '1 : lo_r_q;
		end
	end

endmodule
`default_nettype wire

// ===== design/rwc_back.sv =====
// Back end: multiply stage, saturating accumulators and the frame-end divider.
// Depends on rwc_pkg and rwc_div.
`default_nettype none
module rwc_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          head_valid,
	input  wire rwc_pkg::entry_t               head,
	output logic                               pop,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output logic [rwc_pkg::SUM_BITS-1:0]       total_intensity,
	output logic [rwc_pkg::CENT_BITS-1:0]      centroid_col,
	output logic [rwc_pkg::CENT_BITS-1:0]      centroid_row,
	output logic                               empty_region
);

	logic                           valid_s1, hit_s1, last_s1;
	logic [rwc_pkg::PIXEL_BITS-1:0] pix_s1;
	logic [rwc_pkg::PROD_BITS-1:0]  pc_s1, pr_s1;

	logic [rwc_pkg::SUM_BITS-1:0]  sum_q, sum_nxt;
	logic [rwc_pkg::WSUM_BITS-1:0] wc_q, wr_q, wc_nxt, wr_nxt;
	logic [rwc_pkg::SUM_BITS:0]    sum_add;
	logic [rwc_pkg::WSUM_BITS:0]   wc_add, wr_add;

	logic div_busy, adv_s1, div_start;

	// a frame-end item waits in s1 until the divider is free
	assign adv_s1    = valid_s1 && !(last_s1 && div_busy);
	assign pop       = head_valid && (!valid_s1 || adv_s1);
	assign div_start = adv_s1 && last_s1;

	always_comb begin
		sum_add = {1'b0, sum_q} + (rwc_pkg::SUM_BITS + 1)'(pix_s1);
		wc_add  = {1'b0, wc_q} + (rwc_pkg::WSUM_BITS + 1)'(pc_s1);
		wr_add  = {1'b0, wr_q} + (rwc_pkg::WSUM_BITS + 1)'(pr_s1);
		sum_nxt = sum_q;
		wc_nxt  = wc_q;
		wr_nxt  = wr_q;
		if (hit_s1) begin
			sum_nxt = sum_add[rwc_pkg::SUM_BITS] ? '1 : sum_add[rwc_pkg::SUM_BITS-1:0];
			wc_nxt  = wc_add[rwc_pkg::WSUM_BITS] ? '1 : wc_add[rwc_pkg::WSUM_BITS-1:0];
			wr_nxt  = wr_add[rwc_pkg::WSUM_BITS] ? '1 : wr_add[rwc_pkg::WSUM_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (pop)
			valid_s1 <= 1'b1;
		else if (adv_s1)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			hit_s1  <= head.hit;
			last_s1 <= head.last;
			pix_s1  <= head.pixel;
			pc_s1   <= rwc_pkg::PROD_BITS'(head.pixel) * rwc_pkg::PROD_BITS'(head.dc);
			pr_s1   <= rwc_pkg::PROD_BITS'(head.pixel) * rwc_pkg::PROD_BITS'(head.dr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			wc_q  <= '0;
			wr_q  <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				sum_q <= '0;
				wc_q  <= '0;
				wr_q  <= '0;
			end else begin
				sum_q <= sum_nxt;
				wc_q  <= wc_nxt;
				wr_q  <= wr_nxt;
			end
		end
	end

	rwc_div u_div (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (div_start),
		.den             (sum_nxt),
		.num_c           (wc_nxt),
		.num_r           (wr_nxt),
		.busy            (div_busy),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.total_intensity (total_intensity),
		.centroid_col    (centroid_col),
		.centroid_row    (centroid_row),
		.empty_region    (empty_region)
	);

endmodule
`default_nettype wire

// ===== tb/roi_weighted_centroid_tb.sv =====
// Self-checking bench for roi_weighted_centroid: streams frames, predicts each
// frame's sum and centroids and checks every result transfer against them.
// Depends on rwc_pkg and the roi_weighted_centroid RTL only.
`default_nettype none
module roi_weighted_centroid_tb;
	import rwc_pkg::*;

	localparam int unsigned ITEM_TARGET  = 700;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned QUIET_TAIL   = 120;
	localparam longint unsigned LIMIT_CYCLES = 1_500_000;

	typedef struct {
		logic [SUM_BITS-1:0]  total;
		logic [CENT_BITS-1:0] ccol;
		logic [CENT_BITS-1:0] crow;
		logic                 empty;
	} centroid_t;

	typedef enum {FILL_RANDOM, FILL_ZERO, FILL_MAX, FILL_SPARSE} fill_t;

	class centroid_scoreboard;
		bit [COORD_BITS-1:0] left, top;
		bit [SPAN_BITS-1:0]  roi_w, roi_h, frame_w;
		bit [COORD_BITS-1:0] col, row;
		bit [SUM_BITS-1:0]   sum;
		bit [WSUM_BITS-1:0]  wcol, wrow;
		centroid_t           pending_centroids[$];
		int unsigned         errors;

		function new();
			left    = RST_ROI_LEFT;
			top     = RST_ROI_TOP;
			roi_w   = RST_ROI_WIDTH;
			roi_h   = RST_ROI_HEIGHT;
			frame_w = RST_FRAME_WIDTH;
			col = '0; row = '0; sum = '0; wcol = '0; wrow = '0;
			errors = 0;
		endfunction

		function int unsigned pending();
			return pending_centroids.size();
		endfunction

		function void write_setting(bit [CFG_IDX_BITS-1:0] idx, bit [CFG_DATA_BITS-1:0] data);
			case (idx)
				REG_ROI_LEFT:    left    = data[COORD_BITS-1:0];
				REG_ROI_TOP:     top     = data[COORD_BITS-1:0];
				REG_ROI_WIDTH:   roi_w   = data[SPAN_BITS-1:0];
				REG_ROI_HEIGHT:  roi_h   = data[SPAN_BITS-1:0];
				REG_FRAME_WIDTH: frame_w = data[SPAN_BITS-1:0];
				default: ;
			endcase
		endfunction

		function bit [63:0] sat_add(bit [63:0] a, bit [63:0] b, bit [63:0] top_val);
			if (b > top_val || a > top_val - b)
				return top_val;
			return a + b;
		endfunction

		// (num << FRAC_BITS) / den, truncated, saturating to all ones
		function bit [CENT_BITS-1:0] ratio_fixed(bit [63:0] num, bit [63:0] den);
			bit [63:0] q, r, res;
			q = num / den;
			r = num % den;
			if (q > 64'(COORD_MAX))
				return '1;
			res = (q << FRAC_BITS) + ((r << FRAC_BITS) / den);
			if (res > (64'd1 << CENT_BITS) - 1)
				return '1;
			return res[CENT_BITS-1:0];
		endfunction

		function void take_pixel(bit [PIXEL_BITS-1:0] v, bit last);
			bit [63:0] c, r;
			bit        in_col, in_row;
			centroid_t e;
			c = col;
			r = row;
			in_col = (c >= left) && (c - left < roi_w);
			in_row = (r >= top) && (r - top < roi_h);
			if (in_col && in_row) begin
				sum  = SUM_BITS'(sat_add(sum, v, (64'd1 << SUM_BITS) - 1));
				wcol = WSUM_BITS'(sat_add(wcol, 64'(v) * (c - left),
					(64'd1 << WSUM_BITS) - 1));
				wrow = WSUM_BITS'(sat_add(wrow, 64'(v) * (r - top),
					(64'd1 << WSUM_BITS) - 1));
			end
			if (c + 1 >= frame_w || col == COORD_MAX) begin
				col = '0;
				row = row + COORD_BITS'(1);
			end else begin
				col = col + COORD_BITS'(1);
			end
			if (!last)
				return;
			e.total = sum;
			if (sum == '0) begin
				e.ccol  = '0;
				e.crow  = '0;
				e.empty = 1'b1;
			end else begin
				e.ccol  = ratio_fixed(wcol, sum);
				e.crow  = ratio_fixed(wrow, sum);
				e.empty = 1'b0;
			end
			pending_centroids = {pending_centroids, e};
			col = '0; row = '0; sum = '0; wcol = '0; wrow = '0;
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_centroid(logic [SUM_BITS-1:0] total, logic [CENT_BITS-1:0] ccol,
				logic [CENT_BITS-1:0] crow, logic empty);
			centroid_t e;
			if (pending_centroids.size() == 0) begin
				report("result transfer with no frame outstanding");
				return;
			end
			e = pending_centroids.pop_front();
			if (total !== e.total)
				report($sformatf("total_intensity %0h, predicted %0h", total, e.total));
			if (ccol !== e.ccol)
				report($sformatf("centroid_col %0h, predicted %0h", ccol, e.ccol));
			if (crow !== e.crow)
				report($sformatf("centroid_row %0h, predicted %0h", crow, e.crow));
			if (empty !== e.empty)
				report($sformatf("empty_region %0b, predicted %0b", empty, e.empty));
		endtask
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic                     pix_valid;
	logic                     pix_ready;
	logic [PIXEL_BITS-1:0]    pixel;
	logic                     frame_end;
	logic                     res_valid;
	logic                     res_ready;
	logic [SUM_BITS-1:0]      total_intensity;
	logic [CENT_BITS-1:0]     centroid_col;
	logic [CENT_BITS-1:0]     centroid_row;
	logic                     empty_region;

	centroid_scoreboard sb = new();
	bit          quiet = 1'b0;
	int unsigned pixels_sent = 0;
	int unsigned stall_left = 0;

	roi_weighted_centroid u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.pix_valid       (pix_valid),
		.pix_ready       (pix_ready),
		.pixel           (pixel),
		.frame_end       (frame_end),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.total_intensity (total_intensity),
		.centroid_col    (centroid_col),
		.centroid_row    (centroid_row),
		.empty_region    (empty_region)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side back-pressure in short bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			res_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 6);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	always @(posedge clk)
		if (arst_n && res_valid && res_ready)
			sb.check_centroid(total_intensity, centroid_col, centroid_row, empty_region);

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_BITS'(data);
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		sb.write_setting(idx, CFG_DATA_BITS'(data));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(input int unsigned l, input int unsigned t, input int unsigned w,
			input int unsigned h, input int unsigned fw);
		write_reg(REG_ROI_LEFT, l);
		write_reg(REG_ROI_TOP, t);
		write_reg(REG_ROI_WIDTH, w);
		write_reg(REG_ROI_HEIGHT, h);
		write_reg(REG_FRAME_WIDTH, fw);
	endtask

	task automatic send_pixel(input logic [PIXEL_BITS-1:0] v, input logic last);
		int unsigned gap;
		gap = (!quiet && $urandom_range(0, 11) == 0) ? $urandom_range(1, 7) : 0;
		if (gap != 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pixel     <= v;
		frame_end <= last;
		forever begin
			@(posedge clk);
			if (pix_ready)
				break;
		end
		sb.take_pixel(v, last);
		pixels_sent++;
	endtask

	task automatic send_frame(input int unsigned n, input fill_t fill);
		logic [PIXEL_BITS-1:0] v;
		for (int unsigned i = 0; i < n; i++) begin
			case (fill)
				FILL_ZERO:   v = '0;
				FILL_MAX:    v = '1;
				FILL_SPARSE: v = ($urandom_range(0, 7) == 0) ? PIXEL_BITS'($urandom) : '0;
				default:     v = PIXEL_BITS'($urandom);
			endcase
			send_pixel(v, i == n - 1);
		end
	endtask

	// block is idle once every frame result is back and the divider has drained
	task automatic settle();
		pix_valid <= 1'b0;
		frame_end <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic int unsigned pick(int unsigned lo, int unsigned hi, int unsigned wild);
		if ($urandom_range(0, wild - 1) == 0)
			return $urandom_range(0, (1 << CFG_DATA_BITS) - 1);
		return $urandom_range(lo, hi);
	endfunction

	task automatic random_phase();
		int unsigned fw, frames, n, roll;
		fill_t       fill;
		roll = $urandom_range(0, 11);
		fw = (roll == 0) ? 0 : (roll == 1) ? pick(0, 0, 1) : $urandom_range(1, 12);
		write_all(pick(0, 8, 10), pick(0, 5, 10), pick(0, 10, 10), pick(0, 6, 10), fw);
		frames = $urandom_range(1, 4);
		for (int unsigned f = 0; f < frames; f++) begin
			if (fw == 0 || fw > 12 || $urandom_range(0, 4) == 0)
				n = $urandom_range(1, 40);
			else
				n = fw * $urandom_range(1, 5);
			roll = $urandom_range(0, 15);
			fill = (roll == 0) ? FILL_ZERO : (roll == 1) ? FILL_MAX :
				(roll < 4) ? FILL_SPARSE : FILL_RANDOM;
			send_frame(n, fill);
		end
		settle();
	endtask

	initial begin
		int unsigned start_pixels;
		arst_n    = 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		pix_valid <= 1'b0;
		pixel     <= '0;
		frame_end <= 1'b0;
		res_ready <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: first pixel lies outside the region
		send_pixel('1, 1'b1);
		settle();

		// 2x2 frame fully inside a 2x2 region, then the same region all zero
		write_all(0, 0, 2, 2, 2);
		send_pixel('1, 1'b0);
		send_pixel('0, 1'b0);
		send_pixel(PIXEL_BITS'(1), 1'b0);
		send_pixel('1, 1'b1);
		send_frame(4, FILL_ZERO);
		settle();

		// indexes past the register file must leave the settings alone
		for (int unsigned k = 1; k <= 3; k++)
			write_reg(CFG_IDX_BITS'(REG_FRAME_WIDTH) + CFG_IDX_BITS'(k), $urandom);
		send_frame(4, FILL_RANDOM);
		settle();

		// zero frame width: each pixel starts a new row
		write_all(0, 1, 1, 2, 0);
		send_pixel(PIXEL_BITS'(16'h1234), 1'b0);
		send_pixel('1, 1'b0);
		send_pixel(PIXEL_BITS'(16'h5a5a), 1'b1);
		settle();

		// zero region width selects nothing
		write_reg(REG_ROI_WIDTH, 0);
		send_frame(2, FILL_MAX);
		settle();

		// all-ones settings: region lies beyond the pixels that arrive
		write_all((1 << CFG_DATA_BITS) - 1, (1 << CFG_DATA_BITS) - 1,
			(1 << CFG_DATA_BITS) - 1, (1 << CFG_DATA_BITS) - 1, (1 << CFG_DATA_BITS) - 1);
		send_frame(3, FILL_MAX);
		settle();

		start_pixels = pixels_sent;
		while (pixels_sent - start_pixels < ITEM_TARGET) begin
			if (pixels_sent - start_pixels >= ITEM_TARGET - QUIET_TAIL)
				quiet = 1'b1;
			random_phase();
		end

		settle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * 10);
		$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
design/rwc_pkg.sv
design/rwc_front.sv
design/rwc_fifo.sv
design/rwc_div.sv
design/rwc_back.sv
design/roi_weighted_centroid.sv
tb/roi_weighted_centroid_tb.sv
